// ===== rtl/frcf_pkg.sv =====
// Shared constants and helpers for the flat rotation curve force block.
package frcf_pkg;

    // Fixed point format and widths.
    localparam int FRAC_BITS = 16;
    localparam int CFG_W = 31;
    localparam int POS_W = 32;
    localparam int IDX_W = 3;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_TURN_RADIUS = 3'd0;
    localparam logic [IDX_W-1:0] REG_FLAT_SPEED = 3'd1;
    localparam logic [IDX_W-1:0] REG_VERT_STRENGTH = 3'd2;
    localparam logic [IDX_W-1:0] REG_SCALE_HEIGHT = 3'd3;

    // Reset values: 1.0 for three registers, 0.2 rounded to the grid for the height.
    localparam logic [CFG_W-1:0] ONE_Q = CFG_W'(64'd1 << FRAC_BITS);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(((64'd1 << FRAC_BITS) * 2 + 5) / 10);

    // Pipeline depths.
    localparam int DIV_STEPS = 62;
    localparam int SQRT_STEPS = 32;
    localparam int FRONT_STAGES = 4;
    localparam int DIV_LAT = DIV_STEPS + 1;
    localparam int PIPE_LEN = FRONT_STAGES + DIV_LAT + SQRT_STEPS + 1;
    localparam int DIV_OUT_STAGE = FRONT_STAGES + DIV_LAT - 1;

    // Quotient cap: any quotient at or above this saturates after packing.
    localparam logic [62:0] QUO_CAP = 63'h4000_0000_0000_0000;

    // Apply a sign to a magnitude and saturate to the signed 32-bit range.
    function automatic logic [31:0] sat_pack(input logic neg, input logic [62:0] mag);
        logic [31:0] res;
        begin
            if (neg)
            begin
                if (mag >= 63'h8000_0000)
                    res = 32'h8000_0000;
                else
                    res = 32'(~mag[31:0] + 32'd1);
            end
            else
            begin
                if (mag > 63'h7FFF_FFFF)
                    res = 32'h7FFF_FFFF;
                else
                    res = mag[31:0];
            end
            return res;
        end
    endfunction

endpackage

// ===== rtl/frcf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, quotient capped at 2^62.
module frcf_div (
    input  logic         clk,
    input  logic         en,
    input  logic [127:0] num,
    input  logic [63:0]  den,
    output logic [62:0]  quo
);
    import frcf_pkg::*;

    logic [63:0]           rem_reg [0:DIV_STEPS];
    logic [DIV_STEPS-1:0]  low_reg [0:DIV_STEPS];
    logic [DIV_STEPS-1:0]  quo_reg [0:DIV_STEPS];
    logic [63:0]           den_reg [0:DIV_STEPS];
    logic                  sat_reg [0:DIV_STEPS];

    // Entry stage: overflow test and the first partial remainder.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0] <= num[127:62] >= {2'b00, den};
            rem_reg[0] <= num[125:62];
            low_reg[0] <= num[61:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
        end
    end

    // One compare and subtract per stage.
    for (genvar j = 1; j <= DIV_STEPS; j++)
    begin : g_step
        logic [63:0] trial;
        logic        ge;

        assign trial = {rem_reg[j-1][62:0], low_reg[j-1][DIV_STEPS-1]};
        assign ge = trial >= den_reg[j-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? (trial - den_reg[j-1]) : trial;
                low_reg[j] <= {low_reg[j-1][DIV_STEPS-2:0], 1'b0};
                quo_reg[j] <= {quo_reg[j-1][DIV_STEPS-2:0], ge};
                den_reg[j] <= den_reg[j-1];
                sat_reg[j] <= sat_reg[j-1];
            end
        end
    end

    assign quo = sat_reg[DIV_STEPS] ? QUO_CAP : {1'b0, quo_reg[DIV_STEPS]};

endmodule

// ===== rtl/frcf_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module frcf_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [62:0] val,
    output logic [31:0] root
);
    import frcf_pkg::*;

    logic [62:0] n_reg   [0:SQRT_STEPS-1];
    logic [63:0] res_reg [0:SQRT_STEPS-1];

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_iter
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [62:0] n_in;
        logic [63:0] res_in;
        logic [63:0] trial;
        logic        take;

        if (i == 0)
        begin : g_first
            assign n_in = val;
            assign res_in = '0;
        end
        else
        begin : g_next
            assign n_in = n_reg[i-1];
            assign res_in = res_reg[i-1];
        end

        assign trial = res_in + BIT;
        assign take = {1'b0, n_in} >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i] <= take ? 63'({1'b0, n_in} - trial) : n_in;
                res_reg[i] <= take ? ((res_in >> 1) + BIT) : (res_in >> 1);
            end
        end
    end

    assign root = res_reg[SQRT_STEPS-1][31:0];

endmodule

// ===== rtl/flat_rotation_curve_force.sv =====
// Top level: acceleration of a particle in a flat rotation curve field.
//
// Usage: position words enter on the s_ group (tdata holds pos_x, pos_y,
// pos_z from bit 0 up, signed Q16.16). Each word produces exactly one
// acceleration word on the m_ group (accel_x, accel_y, accel_z, saturated).
// One word is taken every clock cycle while s_tready is high. The pipeline
// has 100 register stages from the accepting edge to m_tvalid.
// The depth is set by the 63 stage restoring divider (an overflow test
// stage, then one quotient bit per stage) followed by a 32 stage square
// root for the vertical term, plus four stages of squaring and partial
// products in front and one packing stage at the end.
// The pipeline advances as a whole; when m_tready is low while a result is
// waiting, every stage holds and s_tready drops, so nothing is lost.
// Configuration registers are written through wr_en, wr_index, wr_data;
// the user must do so only while no word is in flight, as the block does not enforce it.
// Squares of them are registered in the next cycle. Reset loads turn radius 1.0,
// flat speed 1.0, vertical strength 1.0, scale height 0.2 and empties the pipeline.
module flat_rotation_curve_force (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [95:0]                    s_tdata,  // pos_x, pos_y, pos_z
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [95:0]                    m_tdata,  // accel_x, accel_y, accel_z
    input  logic                           wr_en,
    input  logic [frcf_pkg::IDX_W-1:0]     wr_index,
    input  logic [frcf_pkg::CFG_W-1:0]     wr_data
);
    import frcf_pkg::*;

    // Configuration registers and their squares.
    logic [CFG_W-1:0] turn_radius_reg, flat_speed_reg, vert_str_reg, height_reg;
    logic [61:0]      rr_reg, v2_reg, h2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_radius_reg <= ONE_Q;
            flat_speed_reg <= ONE_Q;
            vert_str_reg <= ONE_Q;
            height_reg <= HEIGHT_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_TURN_RADIUS:   turn_radius_reg <= wr_data;
                REG_FLAT_SPEED:    flat_speed_reg <= wr_data;
                REG_VERT_STRENGTH: vert_str_reg <= wr_data;
                REG_SCALE_HEIGHT:  height_reg <= wr_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rr_reg <= 62'(turn_radius_reg) * 62'(turn_radius_reg);
        v2_reg <= 62'(flat_speed_reg) * 62'(flat_speed_reg);
        h2_reg <= 62'(height_reg) * 62'(height_reg);
    end

    // Pipeline control: everything moves unless a result is stuck at the output.
    logic       en;
    logic       vld_reg [0:PIPE_LEN-1];
    logic [2:0] sgn_reg [0:PIPE_LEN-1];

    assign en = !vld_reg[PIPE_LEN-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[PIPE_LEN-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_LEN; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < PIPE_LEN; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // Stage A: magnitudes and signs of the position.
    logic [31:0] px, py, pz;
    logic [31:0] mx_reg, my_reg, mz_reg;

    assign px = s_tdata[31:0];
    assign py = s_tdata[63:32];
    assign pz = s_tdata[95:64];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= px[31] ? (~px + 32'd1) : px;
            my_reg <= py[31] ? (~py + 32'd1) : py;
            mz_reg <= pz[31] ? (~pz + 32'd1) : pz;
            sgn_reg[0] <= {pz[31], py[31], px[31]};
            for (int k = 1; k < PIPE_LEN; k++)
                sgn_reg[k] <= sgn_reg[k-1];
        end
    end

    // Stage B: squares and first partial products.
    logic [63:0] sqx_reg, sqy_reg, sqz_reg;
    logic [62:0] p_reg;
    logic [62:0] pxl_reg, pxh_reg, pyl_reg, pyh_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= 64'(mx_reg) * 64'(mx_reg);
            sqy_reg <= 64'(my_reg) * 64'(my_reg);
            sqz_reg <= 64'(mz_reg) * 64'(mz_reg);
            p_reg <= 63'(vert_str_reg) * 63'(mz_reg);
            pxl_reg <= 63'(mx_reg) * 63'(v2_reg[30:0]);
            pxh_reg <= 63'(mx_reg) * 63'(v2_reg[61:31]);
            pyl_reg <= 63'(my_reg) * 63'(v2_reg[30:0]);
            pyh_reg <= 63'(my_reg) * 63'(v2_reg[61:31]);
        end
    end

    // Stage C: planar denominator, planar numerators, vertical partial products.
    logic [63:0]  r2, q2;
    logic [63:0]  den_c_reg, q2_c_reg;
    logic [127:0] nx_c_reg, ny_c_reg;
    logic [61:0]  hh_reg;
    logic [62:0]  hl_reg;
    logic [63:0]  ll_reg;

    assign r2 = sqx_reg + sqy_reg;
    assign q2 = sqz_reg + 64'(h2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // On the axis the numerator is zero; a unit divisor keeps the quotient zero.
            if (r2 == 64'd0)
                den_c_reg <= 64'd1;
            else if (r2 < 64'(rr_reg))
                den_c_reg <= 64'(rr_reg);
            else
                den_c_reg <= r2;
            // Zero height and zero z give a zero numerator as well.
            q2_c_reg <= (q2 == 64'd0) ? 64'd1 : q2;
            nx_c_reg <= (128'(pxh_reg) << 31) + 128'(pxl_reg);
            ny_c_reg <= (128'(pyh_reg) << 31) + 128'(pyl_reg);
            hh_reg <= 62'(p_reg[62:32]) * 62'(p_reg[62:32]);
            hl_reg <= 63'(p_reg[62:32]) * 63'(p_reg[31:0]);
            ll_reg <= 64'(p_reg[31:0]) * 64'(p_reg[31:0]);
        end
    end

    // Stage D: square of the vertical product, planar operands held.
    logic [63:0]  den_d_reg, q2_d_reg;
    logic [127:0] nx_d_reg, ny_d_reg, nz_d_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_d_reg <= den_c_reg;
            q2_d_reg <= q2_c_reg;
            nx_d_reg <= nx_c_reg;
            ny_d_reg <= ny_c_reg;
            nz_d_reg <= (128'(hh_reg) << 64) + (128'(hl_reg) << 33) + 128'(ll_reg);
        end
    end

    // Dividers.
    logic [62:0] qx, qy, qz;

    frcf_div u_div_x (.clk(clk), .en(en), .num(nx_d_reg), .den(den_d_reg), .quo(qx));
    frcf_div u_div_y (.clk(clk), .en(en), .num(ny_d_reg), .den(den_d_reg), .quo(qy));
    frcf_div u_div_z (.clk(clk), .en(en), .num(nz_d_reg), .den(q2_d_reg), .quo(qz));

    // Square root of the vertical quotient.
    logic [31:0] root;

    frcf_sqrt u_sqrt (.clk(clk), .en(en), .val(qz), .root(root));

    // Planar results are packed and delayed to line up with the root.
    logic [31:0] ax_reg [0:SQRT_STEPS];
    logic [31:0] ay_reg [0:SQRT_STEPS];
    logic [31:0] az_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg[0] <= sat_pack(!sgn_reg[DIV_OUT_STAGE][0], qx);
            ay_reg[0] <= sat_pack(!sgn_reg[DIV_OUT_STAGE][1], qy);
            for (int k = 1; k <= SQRT_STEPS; k++)
            begin
                ax_reg[k] <= ax_reg[k-1];
                ay_reg[k] <= ay_reg[k-1];
            end
            az_reg <= sat_pack(!sgn_reg[PIPE_LEN-2][2], {31'd0, root});
        end
    end

    assign m_tdata = {az_reg, ay_reg[SQRT_STEPS], ax_reg[SQRT_STEPS]};

endmodule
